>>> design/reprojection_inlier_check_defines.svh
// ----------------------------------------------------------------------------
// reprojection inlier check assertion macros
// concurrent checks on clk, disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef REPROJECTION_INLIER_CHECK_DEFINES_SVH
`define REPROJECTION_INLIER_CHECK_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define RIC_ASSERT(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);
`define RIC_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);
`define RIC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define RIC_ASSERT(lbl, expr, msg)
`define RIC_ASSERT_IMPL(lbl, ante, cons, msg)
`define RIC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

>>> design/ric_pkg.sv
// ----------------------------------------------------------------------------
// ric_pkg
// shared types, constants and field extraction for the inlier check
// ----------------------------------------------------------------------------
package ric_pkg;

	localparam int MAX_POINTS = 4096;
	localparam int COUNT_W    = 13;
	localparam logic [COUNT_W-1:0] COUNT_CAP =
		COUNT_W'((MAX_POINTS < 8191) ? MAX_POINTS : 8191);

	localparam int PT_W  = 24;  // Q12.12 point coordinate
	localparam int THR_W = 20;  // Q16.4 squared pixel bound
	localparam int X_W   = 42;  // transformed coordinate, Q.26
	localparam int A_W   = 17;  // mac narrow operand
	localparam int ACC_W = 59;  // mac accumulator
	localparam int N_W   = 58;  // division numerator f * X
	localparam int Q_W   = 57;  // unsigned quotient magnitude
	localparam int D_W   = 41;  // divisor magnitude
	localparam int DIFF_CLAMP = 4096;

	localparam logic [2:0] REG_ROT0  = 3'd0;
	localparam logic [2:0] REG_ROT1  = 3'd1;
	localparam logic [2:0] REG_ROT2  = 3'd2;
	localparam logic [2:0] REG_TRANS = 3'd3;
	localparam logic [2:0] REG_K1    = 3'd4;
	localparam logic [2:0] REG_K2    = 3'd5;

	localparam logic [47:0] ROT0_RST = 48'h4000_0000_0000;
	localparam logic [47:0] ROT1_RST = 48'h0000_4000_0000;
	localparam logic [47:0] ROT2_RST = 48'h0000_0000_4000;

	typedef struct packed {
		logic [47:0] rot0;
		logic [47:0] rot1;
		logic [47:0] rot2;
		logic [62:0] trans;
		logic [63:0] k1;
		logic [63:0] k2;
	} cfg_t;

	typedef struct packed {
		logic signed [PT_W-1:0] p1x;
		logic signed [PT_W-1:0] p1y;
		logic signed [PT_W-1:0] p1z;
		logic signed [PT_W-1:0] p2x;
		logic signed [PT_W-1:0] p2y;
		logic signed [PT_W-1:0] p2z;
		logic [THR_W-1:0]       thr1;
		logic [THR_W-1:0]       thr2;
		logic                   last;
	} item_t;

	typedef struct packed {
		logic               is_inlier;
		logic [COUNT_W-1:0] count;
		logic               end_of_set;
	} res_t;

	typedef struct packed {
		logic                    en;
		logic                    clr;
		logic signed [A_W-1:0]   a;
		logic signed [X_W-1:0]   b;
		logic signed [ACC_W-1:0] addend;
	} mac_req_t;

	typedef struct packed {
		logic                  start;
		logic signed [N_W-1:0] num;
		logic [D_W-1:0]        den;
	} div_req_t;

	function automatic logic signed [15:0] rot_entry(input cfg_t c, input logic [1:0] r,
		input logic [1:0] col);
		logic [47:0] row;
		logic [47:0] sh;
		begin
			unique case (r)
				2'd0: row = c.rot0;
				2'd1: row = c.rot1;
				default: row = c.rot2;
			endcase
			unique case (col)
				2'd0: sh = row >> 32;
				2'd1: sh = row >> 16;
				default: sh = row;
			endcase
			return $signed(sh[15:0]);
		end
	endfunction

	function automatic logic signed [20:0] trans_entry(input cfg_t c, input logic [1:0] i);
		logic [62:0] sh;
		begin
			unique case (i)
				2'd0: sh = c.trans >> 42;
				2'd1: sh = c.trans >> 21;
				default: sh = c.trans;
			endcase
			return $signed(sh[20:0]);
		end
	endfunction

endpackage

>>> design/ric_mac.sv
// ----------------------------------------------------------------------------
// ric_mac
// shared signed multiply-accumulate unit, one product per enabled cycle
// ----------------------------------------------------------------------------
module ric_mac (
	input  logic                             clk,
	input  logic                             arst_n,
	input  ric_pkg::mac_req_t                req,
	output logic signed [ric_pkg::ACC_W-1:0] acc
);
	import ric_pkg::*;

	logic signed [ACC_W-1:0] prod;
	logic signed [ACC_W-1:0] acc_q;

	assign prod = ACC_W'(req.a) * ACC_W'(req.b);
	assign acc  = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (req.en) begin
			acc_q <= (req.clr ? req.addend : acc_q) + prod;
		end
	end

endmodule

>>> design/ric_div.sv
// ----------------------------------------------------------------------------
// ric_div
// restoring divider, one quotient bit per cycle, truncates toward zero
// ----------------------------------------------------------------------------
module ric_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  ric_pkg::div_req_t              req,
	output logic                           done,
	output logic signed [ric_pkg::N_W-1:0] quo
);
	import ric_pkg::*;

	logic [D_W-1:0] rem_q;
	logic [Q_W-1:0] quo_q;
	logic [D_W-1:0] den_q;
	logic           neg_q;
	logic           busy_q;
	logic           done_q;
	logic [5:0]     cnt_q;
	logic [D_W+1:0] trial;
	logic [N_W-1:0] mag;

	assign mag   = req.num[N_W-1] ? N_W'(-req.num) : N_W'(req.num);
	assign trial = {1'b0, rem_q, quo_q[Q_W-1]} - {2'b00, den_q};
	assign done  = done_q;
	assign quo   = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'(Q_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= mag[Q_W-1:0];
			den_q <= req.den;
			neg_q <= req.num[N_W-1];
		end else if (busy_q) begin
			// trial subtract, keep the shifted remainder on borrow
			if (trial[D_W+1]) begin
				rem_q <= {rem_q[D_W-2:0], quo_q[Q_W-1]};
			end else begin
				rem_q <= trial[D_W-1:0];
			end
			quo_q <= {quo_q[Q_W-2:0], ~trial[D_W+1]};
		end
	end

endmodule

>>> design/ric_core.sv
// ----------------------------------------------------------------------------
// ric_core
// sequencer: rigid transforms, depth check, eight projections, error test, inlier count
// ----------------------------------------------------------------------------
`include "reprojection_inlier_check_defines.svh"
module ric_core (
	input  logic            clk,
	input  logic            arst_n,
	input  ric_pkg::cfg_t   cfg,
	input  logic            in_valid,
	output logic            in_ready,
	input  ric_pkg::item_t  in_item,
	output logic            res_valid,
	input  logic            res_ready,
	output ric_pkg::res_t   res
);
	import ric_pkg::*;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_XF   = 4'd1;
	localparam logic [3:0] ST_XW   = 4'd2;
	localparam logic [3:0] ST_CHK  = 4'd3;
	localparam logic [3:0] ST_MUL  = 4'd4;
	localparam logic [3:0] ST_DIV  = 4'd5;
	localparam logic [3:0] ST_DWT  = 4'd6;
	localparam logic [3:0] ST_SQ   = 4'd7;
	localparam logic [3:0] ST_CMP  = 4'd8;
	localparam logic [3:0] ST_OUT  = 4'd9;

	logic [3:0]               state_q;
	logic [2:0]               vi_q;
	logic [1:0]               ti_q;
	logic [2:0]               pix_q;
	logic [1:0]               sq_q;
	logic                     st_pend_q;
	logic [2:0]               st_idx_q;
	logic                     ok1_q;
	logic                     inl_q;
	logic [COUNT_W-1:0]       cnt_q;
	logic [COUNT_W-1:0]       cnt_new;

	item_t                    item_q;
	logic signed [X_W-1:0]    vec_q [6];
	logic signed [ACC_W-1:0]  hold_q;
	logic [12:0]              dabs_q [4];

	mac_req_t                 mac_req;
	logic signed [ACC_W-1:0]  acc;
	div_req_t                 div_req;
	logic                     div_done;
	logic signed [N_W-1:0]    div_quo;

	logic [1:0]               vec_i;
	logic signed [PT_W-1:0]   p1sel;
	logic signed [PT_W-1:0]   p2sel;
	logic signed [X_W-1:0]    xsel;
	logic signed [X_W-1:0]    zsel;
	logic [63:0]              ksel;
	logic [15:0]              fsel;
	logic [15:0]              csel;
	logic signed [ACC_W-1:0]  pixel;
	logic signed [ACC_W:0]    diff;
	logic [ACC_W:0]           mag;
	logic [12:0]              dclamp;
	logic                     depth_ok;

	ric_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mac_req),
		.acc    (acc)
	);

	ric_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.done   (div_done),
		.quo    (div_quo)
	);

	assign in_ready  = (state_q == ST_IDLE);
	assign res_valid = (state_q == ST_OUT);
	assign cnt_new   = (inl_q && (cnt_q < COUNT_CAP)) ? cnt_q + COUNT_W'(1) : cnt_q;
	assign res       = '{is_inlier: inl_q, count: cnt_new, end_of_set: item_q.last};

	// transform term selection
	assign vec_i = (vi_q < 3'd3) ? vi_q[1:0] : 2'(vi_q - 3'd3);

	always_comb begin
		unique case (ti_q)
			2'd0: begin
				p1sel = item_q.p1x;
				p2sel = item_q.p2x;
			end
			2'd1: begin
				p1sel = item_q.p1y;
				p2sel = item_q.p2y;
			end
			default: begin
				p1sel = item_q.p1z;
				p2sel = item_q.p2z;
			end
		endcase
	end

	// projection operand selection
	always_comb begin
		unique case (pix_q)
			3'd0: begin
				xsel = X_W'(item_q.p1x) <<< 14;
				zsel = X_W'(item_q.p1z) <<< 14;
			end
			3'd1: begin
				xsel = vec_q[0];
				zsel = vec_q[2];
			end
			3'd2: begin
				xsel = X_W'(item_q.p1y) <<< 14;
				zsel = X_W'(item_q.p1z) <<< 14;
			end
			3'd3: begin
				xsel = vec_q[1];
				zsel = vec_q[2];
			end
			3'd4: begin
				xsel = vec_q[3];
				zsel = vec_q[5];
			end
			3'd5: begin
				xsel = X_W'(item_q.p2x) <<< 14;
				zsel = X_W'(item_q.p2z) <<< 14;
			end
			3'd6: begin
				xsel = vec_q[4];
				zsel = vec_q[5];
			end
			default: begin
				xsel = X_W'(item_q.p2y) <<< 14;
				zsel = X_W'(item_q.p2z) <<< 14;
			end
		endcase
		ksel = pix_q[2] ? cfg.k2 : cfg.k1;
		fsel = pix_q[1] ? ksel[47:32] : ksel[63:48];
		csel = pix_q[1] ? ksel[15:0] : ksel[31:16];
	end

	assign pixel  = ACC_W'(div_quo) + $signed({43'd0, csel});
	assign diff   = (ACC_W+1)'(hold_q) - (ACC_W+1)'(pixel);
	assign mag    = diff[ACC_W] ? (ACC_W+1)'(-diff) : (ACC_W+1)'(diff);
	assign dclamp = (mag > (ACC_W+1)'(DIFF_CLAMP)) ? 13'(DIFF_CLAMP) : mag[12:0];

	assign depth_ok = (item_q.p1z > 0) && (item_q.p2z > 0) && (vec_q[2] > 0) && (vec_q[5] > 0);

	always_comb begin
		mac_req = '0;
		div_req = '0;
		div_req.num = N_W'(acc);
		div_req.den = zsel[D_W-1:0];
		unique case (state_q)
			ST_XF: begin
				mac_req.en  = 1'b1;
				mac_req.clr = (ti_q == 2'd0);
				if (vi_q < 3'd3) begin
					mac_req.a      = A_W'(rot_entry(cfg, vec_i, ti_q));
					mac_req.b      = X_W'(p2sel);
					mac_req.addend = ACC_W'(trans_entry(cfg, vec_i)) <<< 14;
				end else begin
					mac_req.a = A_W'(rot_entry(cfg, ti_q, vec_i));
					mac_req.b = X_W'(p1sel) - X_W'(trans_entry(cfg, ti_q));
				end
			end
			ST_MUL: begin
				mac_req.en  = 1'b1;
				mac_req.clr = 1'b1;
				mac_req.a   = $signed({1'b0, fsel});
				mac_req.b   = xsel;
			end
			ST_DIV: begin
				div_req.start = 1'b1;
			end
			ST_SQ: begin
				mac_req.en  = 1'b1;
				mac_req.clr = ~sq_q[0];
				mac_req.a   = $signed({4'd0, dabs_q[sq_q]});
				mac_req.b   = $signed({29'd0, dabs_q[sq_q]});
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			vi_q      <= '0;
			ti_q      <= '0;
			pix_q     <= '0;
			sq_q      <= '0;
			st_pend_q <= 1'b0;
			st_idx_q  <= '0;
			ok1_q     <= 1'b0;
			inl_q     <= 1'b0;
			cnt_q     <= '0;
		end else begin
			st_pend_q <= (state_q == ST_XF) && (ti_q == 2'd2);
			st_idx_q  <= vi_q;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_XF;
						vi_q    <= '0;
						ti_q    <= '0;
					end
				end
				ST_XF: begin
					if (ti_q == 2'd2) begin
						ti_q <= '0;
						vi_q <= vi_q + 3'd1;
						if (vi_q == 3'd5) begin
							state_q <= ST_XW;
						end
					end else begin
						ti_q <= ti_q + 2'd1;
					end
				end
				ST_XW: begin
					state_q <= ST_CHK;
				end
				ST_CHK: begin
					pix_q <= '0;
					if (depth_ok) begin
						state_q <= ST_MUL;
					end else begin
						inl_q   <= 1'b0;
						state_q <= ST_OUT;
					end
				end
				ST_MUL: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					state_q <= ST_DWT;
				end
				ST_DWT: begin
					if (div_done) begin
						pix_q <= pix_q + 3'd1;
						if (pix_q == 3'd7) begin
							sq_q    <= '0;
							state_q <= ST_SQ;
						end else begin
							state_q <= ST_MUL;
						end
					end
				end
				ST_SQ: begin
					sq_q <= sq_q + 2'd1;
					// accumulator holds the image-one error here
					if (sq_q == 2'd2) begin
						ok1_q <= acc < $signed({35'd0, item_q.thr1, 4'd0});
					end
					if (sq_q == 2'd3) begin
						state_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					inl_q   <= ok1_q && (acc < $signed({35'd0, item_q.thr2, 4'd0}));
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (res_ready) begin
						cnt_q   <= item_q.last ? '0 : cnt_new;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_q <= in_item;
		end
		if (st_pend_q) begin
			vec_q[st_idx_q] <= X_W'(acc);
		end
		if ((state_q == ST_DWT) && div_done) begin
			if (!pix_q[0]) begin
				hold_q <= pixel;
			end else begin
				dabs_q[pix_q[2:1]] <= dclamp;
			end
		end
	end

	`RIC_ASSERT(a_cnt_cap, cnt_q <= COUNT_CAP, "inlier count above cap")
	`RIC_ASSERT_NEXT(a_accept_xf, in_valid && in_ready, state_q == ST_XF, "transfer not followed by transform")
	`RIC_ASSERT_IMPL(a_div_done, div_done, state_q == ST_DWT, "divider finished outside wait")
	`RIC_ASSERT_IMPL(a_div_den, state_q == ST_DIV, zsel > 0, "division with non-positive depth")

endmodule

>>> design/reprojection_inlier_check.sv
// one item in flight: a new input is accepted only after the last result has left the core;
// a failed depth check skips the projections and the error test
// the serial divider dominates the processing time: eight divisions of 57 one-bit steps
// each, plus the shared multiply-accumulate work for the two rigid transforms
// arst_n clears control, the inlier count and loads identity rotation, zero t and K
// ----------------------------------------------------------------------------
// reprojection_inlier_check
// two-view reprojection error inlier test with a running inlier count
// ----------------------------------------------------------------------------
module reprojection_inlier_check (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// cam1_point_x, y, z, cam2_point_x, y, z, max_error_cam1, max_error_cam2
	input  logic [183:0] s_tdata,
	input  logic         s_tlast,
	output logic         m_tvalid,
	input  logic         m_tready,
	// is_inlier, inlier_count, two zero bits
	output logic [15:0]  m_tdata,
	output logic         m_tlast,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [63:0]  cfg_data
);
	import ric_pkg::*;

	cfg_t   cfg_q;
	item_t  item;
	res_t   res;
	logic   res_valid;
	logic   res_ready;
	logic   m_tvalid_q;
	res_t   out_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rot0  <= ROT0_RST;
			cfg_q.rot1  <= ROT1_RST;
			cfg_q.rot2  <= ROT2_RST;
			cfg_q.trans <= '0;
			cfg_q.k1    <= '0;
			cfg_q.k2    <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_ROT0:  cfg_q.rot0  <= cfg_data[47:0];
				REG_ROT1:  cfg_q.rot1  <= cfg_data[47:0];
				REG_ROT2:  cfg_q.rot2  <= cfg_data[47:0];
				REG_TRANS: cfg_q.trans <= cfg_data[62:0];
				REG_K1:    cfg_q.k1    <= cfg_data;
				REG_K2:    cfg_q.k2    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign item.p1x  = $signed(s_tdata[23:0]);
	assign item.p1y  = $signed(s_tdata[47:24]);
	assign item.p1z  = $signed(s_tdata[71:48]);
	assign item.p2x  = $signed(s_tdata[95:72]);
	assign item.p2y  = $signed(s_tdata[119:96]);
	assign item.p2z  = $signed(s_tdata[143:120]);
	assign item.thr1 = s_tdata[163:144];
	assign item.thr2 = s_tdata[183:164];
	assign item.last = s_tlast;

	ric_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_item   (item),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// output register, refilled in the cycle its transfer completes
	assign res_ready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_ready) begin
			m_tvalid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {2'b00, out_q.count, out_q.is_inlier};
	assign m_tlast  = out_q.end_of_set;

endmodule
